/* rtl/core/ids_pkg.sv */
// Package for the interception duration solver: widths, constants, payload types.
// Used by every module of the solver core; it depends on nothing else.
package ids_pkg;

    localparam int FRAC_BITS = 16;
    localparam int TICK_BITS = 16;

    localparam int IN_W   = 24;
    localparam int ZOFF_W = 22;
    localparam int MSPD_W = 21;
    localparam int TPER_W = 17;
    localparam int DUR_W  = 32;

    localparam int V_W    = 24;
    localparam int D_W    = 26;
    localparam int VEX_W  = 24;
    localparam int VE_W   = 20;
    localparam int VE_SHIFT = 27;
    localparam logic [VEX_W-1:0] VE_MUL = 24'd13421773;

    localparam int QA_W   = 49;
    localparam int UA_W   = 48;
    localparam int HB_W   = 51;
    localparam int HBM_W  = 50;
    localparam int QC_W   = 52;
    localparam int UB_W   = 52;
    localparam int HALF_W = 26;
    localparam int DSC_W  = 102;
    localparam int SQ_W   = 51;
    localparam int SQ_R_W = 53;
    localparam int N_W    = 53;
    localparam int NUM_W  = 52;
    localparam int DEN_W  = 52;
    localparam int Q_W    = 45;
    localparam int TN_W   = Q_W + 1;

    localparam logic [63:0] EPS_Q2 = ((64'd1 << (2 * FRAC_BITS)) + 64'd5000) / 64'd10000;
    localparam logic [63:0] EPS_T  = ((64'd1 << FRAC_BITS) + 64'd5000) / 64'd10000;
    localparam logic [Q_W-1:0] FALLBACK_T = Q_W'(64'd4 << FRAC_BITS);
    localparam logic [Q_W-1:0] T_CAP = Q_W'(1) << (Q_W - 1);
    localparam logic [TICK_BITS-1:0] TICK_MAX = '1;

    localparam int TDIV_LAT  = Q_W + 1;
    localparam int FRONT_LAT = 8;
    localparam int QDEPTH    = 4;
    localparam int QPTR_W    = 2;
    localparam int QCNT_W    = 3;
    localparam int OUT_MAX   = FRONT_LAT + QDEPTH;
    localparam int OUT_W     = 4;

    localparam logic [1:0] CASE_QUAD = 2'd0;
    localparam logic [1:0] CASE_LIN  = 2'd1;
    localparam logic [1:0] CASE_FALL = 2'd2;

    localparam logic [1:0] REG_ZOFF = 2'd0;
    localparam logic [1:0] REG_MSPD = 2'd1;
    localparam logic [1:0] REG_TPER = 2'd2;

    typedef struct packed {
        logic signed [IN_W-1:0] obj_x;
        logic signed [IN_W-1:0] obj_y;
        logic signed [IN_W-1:0] obj_z;
        logic signed [IN_W-1:0] obj_vx;
        logic signed [IN_W-1:0] obj_vy;
        logic signed [IN_W-1:0] obj_vz;
        logic signed [IN_W-1:0] tool_x;
        logic signed [IN_W-1:0] tool_y;
        logic signed [IN_W-1:0] tool_z;
    } ids_in_t;

    typedef struct packed {
        logic [TICK_BITS-1:0] tick_count;
        logic [DUR_W-1:0]     duration_q16;
        logic [1:0]           solve_case;
    } ids_out_t;

    typedef struct packed {
        logic signed [ZOFF_W-1:0] z_offset;
        logic [MSPD_W-1:0]        max_speed;
        logic [TPER_W-1:0]        tick_period;
    } ids_cfg_t;

    typedef struct packed {
        logic [1:0]               path;
        logic                     qa_neg;
        logic signed [HB_W-1:0]   hb;
        logic [UA_W-1:0]          ua;
        logic [UB_W-1:0]          ub;
        logic [QC_W-1:0]          qc;
        logic [DSC_W-1:0]         dsc;
    } ids_job_t;

endpackage

/* rtl/core/ids_front.sv */
// Front part of the solver: forms the quadratic coefficients and the discriminant
// and classifies each item. Depends on ids_pkg.
module ids_front import ids_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  ids_in_t  in_item,
    input  ids_cfg_t cfg,
    output logic     push,
    output ids_job_t job
);

    logic [FRONT_LAT-1:0] vld_reg;

    logic signed [D_W-1:0] dx_reg, dy_reg, dz_reg, dx_next, dy_next, dz_next;
    logic signed [V_W-1:0] vx_reg, vy_reg, vz_reg;
    logic [2*VEX_W-1:0]    vep_reg, vep_next;
    logic [VEX_W-1:0]      vex;

    logic [VE_W-1:0]       ve;
    logic signed [47:0]    vvx_reg, vvy_reg, vvz_reg;
    logic signed [49:0]    vdx_reg, vdy_reg, vdz_reg;
    logic signed [51:0]    ddx_reg, ddy_reg, ddz_reg;
    logic [2*VE_W-1:0]     vesq_reg;

    logic signed [QA_W-1:0] qa_reg;
    logic signed [HB_W-1:0] hb_reg;
    logic [QC_W-1:0]        qc_reg;

    ids_job_t job4_reg, job5_reg, job6_reg, job7_reg, job8_reg, job4_next, job8_next;
    logic [HBM_W-1:0] hbm4_reg, hbm_next;
    logic [2*HALF_W-1:0] ha, ua_ext;
    logic [2*HALF_W-1:0] h_hh_reg, h_hl_reg, h_ll_reg;
    logic [2*HALF_W-1:0] c_hh_reg, c_hl_reg, c_lh_reg, c_ll_reg;
    logic [2*HALF_W-1:0] h_hh6_reg, h_ll6_reg, c_hh6_reg, c_ll6_reg;
    logic [2*HALF_W:0]   h_mid6_reg, c_mid6_reg;
    logic [DSC_W+1:0]    h2_full, ac_full;
    logic [DSC_W-1:0]    h2_reg, ac_reg;

    always_comb
    begin
        dx_next = D_W'(in_item.obj_x) - D_W'(in_item.tool_x);
        dy_next = D_W'(in_item.obj_y) - D_W'(in_item.tool_y);
        dz_next = D_W'(in_item.obj_z) + D_W'(cfg.z_offset) - D_W'(in_item.tool_z);
        vex = VEX_W'({cfg.max_speed, 2'b00}) + VEX_W'(5);
        vep_next = vex * VE_MUL;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[FRONT_LAT-2:0], in_valid};
        end
    end

    assign ve = vep_reg[VE_SHIFT +: VE_W];

    always_comb
    begin
        hbm_next = hb_reg[HB_W-1] ? HBM_W'(-hb_reg) : HBM_W'(hb_reg);
        job4_next.qa_neg = qa_reg[QA_W-1];
        job4_next.ua = qa_reg[QA_W-1] ? UA_W'(-qa_reg) : UA_W'(qa_reg);
        job4_next.hb = hb_reg;
        job4_next.ub = UB_W'({hbm_next, 1'b0});
        job4_next.qc = qc_reg;
        job4_next.dsc = '0;
        if (64'(job4_next.ua) >= EPS_Q2)
        begin
            job4_next.path = CASE_QUAD;
        end
        else if (64'(job4_next.ub) >= EPS_Q2 && hb_reg[HB_W-1])
        begin
            job4_next.path = CASE_LIN;
        end
        else
        begin
            job4_next.path = CASE_FALL;
        end
    end

    assign ha = (2*HALF_W)'(hbm4_reg);
    assign ua_ext = (2*HALF_W)'(job4_reg.ua);

    always_comb
    begin
        h2_full = ((DSC_W+2)'(h_hh6_reg) << (2*HALF_W)) + ((DSC_W+2)'(h_mid6_reg) << HALF_W)
                + (DSC_W+2)'(h_ll6_reg);
        ac_full = ((DSC_W+2)'(c_hh6_reg) << (2*HALF_W)) + ((DSC_W+2)'(c_mid6_reg) << HALF_W)
                + (DSC_W+2)'(c_ll6_reg);
        job8_next = job7_reg;
        job8_next.dsc = job7_reg.qa_neg ? (h2_reg + ac_reg) : (h2_reg - ac_reg);
        if (job7_reg.path == CASE_QUAD && !job7_reg.qa_neg && ac_reg > h2_reg)
        begin
            job8_next.path = CASE_FALL;
        end
    end

    always_ff @(posedge clk)
    begin
        dx_reg <= dx_next;
        dy_reg <= dy_next;
        dz_reg <= dz_next;
        vx_reg <= in_item.obj_vx;
        vy_reg <= in_item.obj_vy;
        vz_reg <= in_item.obj_vz;
        vep_reg <= vep_next;

        vvx_reg <= vx_reg * vx_reg;
        vvy_reg <= vy_reg * vy_reg;
        vvz_reg <= vz_reg * vz_reg;
        vdx_reg <= vx_reg * dx_reg;
        vdy_reg <= vy_reg * dy_reg;
        vdz_reg <= vz_reg * dz_reg;
        ddx_reg <= dx_reg * dx_reg;
        ddy_reg <= dy_reg * dy_reg;
        ddz_reg <= dz_reg * dz_reg;
        vesq_reg <= ve * ve;

        qa_reg <= QA_W'(vvx_reg) + QA_W'(vvy_reg) + QA_W'(vvz_reg)
                - $signed(QA_W'(vesq_reg));
        hb_reg <= HB_W'(vdx_reg) + HB_W'(vdy_reg) + HB_W'(vdz_reg);
        qc_reg <= QC_W'(ddx_reg) + QC_W'(ddy_reg) + QC_W'(ddz_reg);

        job4_reg <= job4_next;
        hbm4_reg <= hbm_next;

        h_hh_reg <= ha[2*HALF_W-1:HALF_W] * ha[2*HALF_W-1:HALF_W];
        h_hl_reg <= ha[2*HALF_W-1:HALF_W] * ha[HALF_W-1:0];
        h_ll_reg <= ha[HALF_W-1:0] * ha[HALF_W-1:0];
        c_hh_reg <= ua_ext[2*HALF_W-1:HALF_W] * job4_reg.qc[2*HALF_W-1:HALF_W];
        c_hl_reg <= ua_ext[2*HALF_W-1:HALF_W] * job4_reg.qc[HALF_W-1:0];
        c_lh_reg <= ua_ext[HALF_W-1:0] * job4_reg.qc[2*HALF_W-1:HALF_W];
        c_ll_reg <= ua_ext[HALF_W-1:0] * job4_reg.qc[HALF_W-1:0];
        job5_reg <= job4_reg;

        h_hh6_reg <= h_hh_reg;
        h_ll6_reg <= h_ll_reg;
        h_mid6_reg <= {h_hl_reg, 1'b0};
        c_hh6_reg <= c_hh_reg;
        c_ll6_reg <= c_ll_reg;
        c_mid6_reg <= (2*HALF_W+1)'(c_hl_reg) + (2*HALF_W+1)'(c_lh_reg);
        job6_reg <= job5_reg;

        h2_reg <= h2_full[DSC_W-1:0];
        ac_reg <= ac_full[DSC_W-1:0];
        job7_reg <= job6_reg;

        job8_reg <= job8_next;
    end

    assign push = vld_reg[FRONT_LAT-1];
    assign job = job8_reg;

endmodule

/* rtl/core/ids_queue.sv */
// Short queue between the front and the back of the solver.
// Depends on ids_pkg.
module ids_queue import ids_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  ids_job_t push_job,
    input  logic     pop,
    output logic     empty,
    output ids_job_t head
);

    ids_job_t            mem_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]   cnt_reg, cnt_next;

    always_comb
    begin
        cnt_next = cnt_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    assign empty = (cnt_reg == '0);
    assign head = mem_reg[rd_ptr_reg];

endmodule

/* rtl/core/ids_tdiv.sv */
// Pipelined time divider: min(floor(num * 2^FRAC_BITS / den), T_CAP), one bit a stage.
// Depends on ids_pkg.
module ids_tdiv import ids_pkg::*; (
    input  logic             clk,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [Q_W-1:0]   quot
);

    localparam int LOW_W = Q_W - FRAC_BITS;

    logic [DEN_W-1:0] r_reg   [0:Q_W];
    logic [DEN_W-1:0] d_reg   [0:Q_W];
    logic [Q_W-1:0]   lo_reg  [0:Q_W];
    logic [Q_W-1:0]   q_reg   [0:Q_W];
    logic             sat_reg [0:Q_W];

    logic [NUM_W+FRAC_BITS:0]     n_full;
    logic [DEN_W+Q_W:0]           cap_lim;

    always_comb
    begin
        n_full = (NUM_W+FRAC_BITS+1)'({num, {FRAC_BITS{1'b0}}});
        cap_lim = ((DEN_W+Q_W+1)'(den) << (Q_W - 1)) + (DEN_W+Q_W+1)'(den);
    end

    always_ff @(posedge clk)
    begin
        sat_reg[0] <= (DEN_W+Q_W+1)'(n_full) >= cap_lim;
        r_reg[0]   <= DEN_W'(num >> LOW_W);
        lo_reg[0]  <= {num[LOW_W-1:0], {FRAC_BITS{1'b0}}};
        d_reg[0]   <= den;
        q_reg[0]   <= '0;
    end

    for (genvar k = 0; k < Q_W; k++)
    begin : g_step
        logic [DEN_W:0]   rt;
        logic             ge;
        logic [DEN_W-1:0] r_next;

        always_comb
        begin
            rt = {r_reg[k], lo_reg[k][Q_W-1-k]};
            ge = rt >= {1'b0, d_reg[k]};
            r_next = ge ? DEN_W'(rt - {1'b0, d_reg[k]}) : DEN_W'(rt);
        end

        always_ff @(posedge clk)
        begin
            r_reg[k+1]   <= r_next;
            d_reg[k+1]   <= d_reg[k];
            lo_reg[k+1]  <= lo_reg[k];
            q_reg[k+1]   <= {q_reg[k][Q_W-2:0], ge};
            sat_reg[k+1] <= sat_reg[k];
        end
    end

    assign quot = sat_reg[Q_W] ? T_CAP : q_reg[Q_W];

endmodule

/* rtl/core/ids_back.sv */
// Back part of the solver: square root, root selection, time division and tick rounding.
// Depends on ids_pkg and ids_tdiv.
module ids_back import ids_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     pop,
    input  ids_job_t head,
    input  ids_cfg_t cfg,
    output logic     done,
    output ids_out_t result
);

    typedef struct packed {
        logic       v0;
        logic       v1;
        logic [1:0] path;
    } side_t;

    logic [TPER_W-1:0] dt;
    assign dt = (cfg.tick_period == '0) ? TPER_W'(1) : cfg.tick_period;

    // Square root, two radicand bits a stage.
    ids_job_t          sq_job_reg [0:SQ_W];
    logic [SQ_R_W-1:0] sq_r_reg   [0:SQ_W];
    logic [SQ_W-1:0]   sq_s_reg   [0:SQ_W];
    logic              sq_vld_reg [0:SQ_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_vld_reg[0] <= 1'b0;
        end
        else
        begin
            sq_vld_reg[0] <= pop;
        end
    end

    always_ff @(posedge clk)
    begin
        sq_job_reg[0] <= head;
        sq_r_reg[0] <= '0;
        sq_s_reg[0] <= '0;
    end

    for (genvar k = 0; k < SQ_W; k++)
    begin : g_sqrt
        logic [SQ_R_W+1:0] rt, tr;
        logic              ge;

        always_comb
        begin
            rt = {sq_r_reg[k], sq_job_reg[k].dsc[DSC_W-1-2*k -: 2]};
            tr = (SQ_R_W+2)'({sq_s_reg[k], 2'b01});
            ge = rt >= tr;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sq_vld_reg[k+1] <= 1'b0;
            end
            else
            begin
                sq_vld_reg[k+1] <= sq_vld_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            sq_job_reg[k+1] <= sq_job_reg[k];
            sq_r_reg[k+1] <= ge ? SQ_R_W'(rt - tr) : SQ_R_W'(rt);
            sq_s_reg[k+1] <= {sq_s_reg[k][SQ_W-2:0], ge};
        end
    end

    // Root numerators and divider operands.
    ids_job_t            rj;
    logic signed [N_W-1:0] n0, n1, s_ext;
    logic                c0, c1;
    logic [NUM_W-1:0]    m0, m1;
    logic [NUM_W-1:0]    numa_reg, numb_reg;
    logic [DEN_W-1:0]    dena_reg, denb_reg;
    side_t               side_next, side_reg;
    logic                rt_vld_reg;

    always_comb
    begin
        rj = sq_job_reg[SQ_W];
        s_ext = $signed(N_W'(sq_s_reg[SQ_W]));
        n0 = -N_W'(rj.hb) + s_ext;
        n1 = -N_W'(rj.hb) - s_ext;
        m0 = n0[N_W-1] ? NUM_W'(-n0) : NUM_W'(n0);
        m1 = n1[N_W-1] ? NUM_W'(-n1) : NUM_W'(n1);
        c0 = rj.qa_neg ? n0[N_W-1] : (!n0[N_W-1] && n0 != '0);
        c1 = rj.qa_neg ? n1[N_W-1] : (!n1[N_W-1] && n1 != '0);
        side_next.path = rj.path;
        side_next.v0 = (rj.path == CASE_QUAD) && c0;
        side_next.v1 = (rj.path == CASE_LIN) || ((rj.path == CASE_QUAD) && c1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rt_vld_reg <= 1'b0;
        end
        else
        begin
            rt_vld_reg <= sq_vld_reg[SQ_W];
        end
    end

    always_ff @(posedge clk)
    begin
        side_reg <= side_next;
        numa_reg <= m0;
        dena_reg <= DEN_W'(rj.ua);
        numb_reg <= (rj.path == CASE_LIN) ? NUM_W'(rj.qc) : m1;
        denb_reg <= (rj.path == CASE_LIN) ? DEN_W'(rj.ub) : DEN_W'(rj.ua);
    end

    logic [Q_W-1:0] ta, tb;

    ids_tdiv u_diva (
        .clk  (clk),
        .num  (numa_reg),
        .den  (dena_reg),
        .quot (ta)
    );

    ids_tdiv u_divb (
        .clk  (clk),
        .num  (numb_reg),
        .den  (denb_reg),
        .quot (tb)
    );

    side_t dl_side_reg [0:TDIV_LAT-1];
    logic  dl_vld_reg  [0:TDIV_LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dl_vld_reg[0] <= 1'b0;
        end
        else
        begin
            dl_vld_reg[0] <= rt_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        dl_side_reg[0] <= side_reg;
    end

    for (genvar k = 1; k < TDIV_LAT; k++)
    begin : g_delay
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dl_vld_reg[k] <= 1'b0;
            end
            else
            begin
                dl_vld_reg[k] <= dl_vld_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            dl_side_reg[k] <= dl_side_reg[k-1];
        end
    end

    // Candidate selection.
    side_t          ds;
    logic           ok0, ok1;
    logic [Q_W-1:0] t_next, t_reg;
    logic [1:0]     case_next, case_reg;
    logic           ch_vld_reg;

    always_comb
    begin
        ds = dl_side_reg[TDIV_LAT-1];
        ok0 = ds.v0 && (64'(ta) > EPS_T);
        ok1 = ds.v1 && (64'(tb) > EPS_T);
        priority if (ok0 && ok1)
        begin
            t_next = (ta < tb) ? ta : tb;
        end
        else if (ok0)
        begin
            t_next = ta;
        end
        else if (ok1)
        begin
            t_next = tb;
        end
        else
        begin
            t_next = FALLBACK_T;
        end
        if (!ok0 && !ok1)
        begin
            case_next = CASE_FALL;
        end
        else
        begin
            case_next = (ds.path == CASE_LIN) ? CASE_LIN : CASE_QUAD;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ch_vld_reg <= 1'b0;
        end
        else
        begin
            ch_vld_reg <= dl_vld_reg[TDIV_LAT-1];
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg <= t_next;
        case_reg <= case_next;
    end

    // Tick rounding: ceiling division by dt, one quotient bit a stage.
    logic [TN_W-1:0]          tnum;
    logic [TPER_W+TICK_BITS:0] tlim;

    logic [TPER_W-1:0]    tk_r_reg    [0:TICK_BITS];
    logic [TICK_BITS-1:0] tk_low_reg  [0:TICK_BITS];
    logic [TICK_BITS-1:0] tk_q_reg    [0:TICK_BITS];
    logic                 tk_sat_reg  [0:TICK_BITS];
    logic [1:0]           tk_case_reg [0:TICK_BITS];
    logic                 tk_vld_reg  [0:TICK_BITS];

    always_comb
    begin
        tnum = TN_W'(t_reg) + TN_W'(dt) - TN_W'(1);
        tlim = ((TPER_W+TICK_BITS+1)'(dt) << TICK_BITS) - (TPER_W+TICK_BITS+1)'(dt);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tk_vld_reg[0] <= 1'b0;
        end
        else
        begin
            tk_vld_reg[0] <= ch_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        tk_sat_reg[0] <= (TN_W + TPER_W)'(tnum) >= (TN_W + TPER_W)'(tlim);
        tk_r_reg[0] <= TPER_W'(tnum >> TICK_BITS);
        tk_low_reg[0] <= tnum[TICK_BITS-1:0];
        tk_q_reg[0] <= '0;
        tk_case_reg[0] <= case_reg;
    end

    for (genvar k = 0; k < TICK_BITS; k++)
    begin : g_tick
        logic [TPER_W:0] rt;
        logic            ge;

        always_comb
        begin
            rt = {tk_r_reg[k], tk_low_reg[k][TICK_BITS-1-k]};
            ge = rt >= {1'b0, dt};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                tk_vld_reg[k+1] <= 1'b0;
            end
            else
            begin
                tk_vld_reg[k+1] <= tk_vld_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            tk_r_reg[k+1] <= ge ? TPER_W'(rt - {1'b0, dt}) : TPER_W'(rt);
            tk_low_reg[k+1] <= tk_low_reg[k];
            tk_q_reg[k+1] <= {tk_q_reg[k][TICK_BITS-2:0], ge};
            tk_sat_reg[k+1] <= tk_sat_reg[k];
            tk_case_reg[k+1] <= tk_case_reg[k];
        end
    end

    logic [TICK_BITS-1:0] ticks_next, ticks_reg;
    logic [1:0]           fcase_reg;
    logic                 fin_vld_reg;

    always_comb
    begin
        priority if (tk_sat_reg[TICK_BITS])
        begin
            ticks_next = TICK_MAX;
        end
        else if (tk_q_reg[TICK_BITS] == '0)
        begin
            ticks_next = TICK_BITS'(1);
        end
        else
        begin
            ticks_next = tk_q_reg[TICK_BITS];
        end
    end

    always_ff @(posedge clk)
    begin
        ticks_reg <= ticks_next;
        fcase_reg <= tk_case_reg[TICK_BITS];
    end

    logic [TICK_BITS+TPER_W-1:0] dur;
    ids_out_t result_reg, result_next;
    logic     done_reg;

    always_comb
    begin
        dur = (TICK_BITS+TPER_W)'(ticks_reg) * (TICK_BITS+TPER_W)'(dt);
        result_next.tick_count = ticks_reg;
        result_next.solve_case = fcase_reg;
        result_next.duration_q16 = (dur > (TICK_BITS+TPER_W)'({DUR_W{1'b1}}))
                                 ? {DUR_W{1'b1}} : DUR_W'(dur);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fin_vld_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            fin_vld_reg <= tk_vld_reg[TICK_BITS];
            done_reg <= fin_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done = done_reg;
    assign result = result_reg;

endmodule

/* rtl/core/intercept_duration_solver_core.sv */
// Top level of the interception duration solver: register port, front, queue and back.
// Depends on ids_pkg, ids_front, ids_queue and ids_back.
//
//   Channel    Handshake                     Beat
//   input      start, busy (taken: start&!busy)  in_item (ids_in_t)
//   result     done (one cycle, no stall)    result (ids_out_t)
//   config     psel, penable, pwrite, pready  paddr, pwdata, prdata
//
// One item is taken per cycle while busy is low; busy stays low in steady operation.
// The path from the accepting edge to done runs mostly through the 51-stage square root,
// the 46-stage time dividers and the 16-stage tick divider.
// Reset clears all valid bits and loads the register reset values.
// The receiver cannot stall; busy only rises if the queue could overflow.
module intercept_duration_solver_core import ids_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  ids_in_t     in_item,
    output logic        done,
    output ids_out_t    result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    ids_cfg_t         cfg_reg;
    logic [1:0]       reg_idx;
    logic             wr_en;
    logic             accept;
    logic             push, pop, q_empty;
    ids_job_t         push_job, head;
    logic [OUT_W-1:0] outst_reg, outst_next;

    assign pready = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.z_offset <= '0;
            cfg_reg.max_speed <= MSPD_W'(32768);
            cfg_reg.tick_period <= TPER_W'(655);
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_ZOFF: cfg_reg.z_offset <= pwdata[ZOFF_W-1:0];
                REG_MSPD: cfg_reg.max_speed <= pwdata[MSPD_W-1:0];
                REG_TPER: cfg_reg.tick_period <= pwdata[TPER_W-1:0];
                default:  cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_ZOFF: prdata = 32'(cfg_reg.z_offset);
            REG_MSPD: prdata = 32'(cfg_reg.max_speed);
            REG_TPER: prdata = 32'(cfg_reg.tick_period);
            default:  prdata = '0;
        endcase
    end

    assign accept = start && !busy;
    assign pop = !q_empty;
    assign busy = (outst_reg >= OUT_W'(OUT_MAX));

    always_comb
    begin
        outst_next = outst_reg + OUT_W'(accept) - OUT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outst_reg <= '0;
        end
        else
        begin
            outst_reg <= outst_next;
        end
    end

    ids_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (accept),
        .in_item  (in_item),
        .cfg      (cfg_reg),
        .push     (push),
        .job      (push_job)
    );

    ids_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .empty    (q_empty),
        .head     (head)
    );

    ids_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .pop    (pop),
        .head   (head),
        .cfg    (cfg_reg),
        .done   (done),
        .result (result)
    );

endmodule

/* rtl/core/ids_checker.sv */
// Port-level checks for the interception duration solver, bound to its top level.
// Depends on ids_pkg.
module ids_checker import ids_pkg::*; (
    input logic     clk,
    input logic     rst_n,
    input logic     done,
    input ids_out_t result
);

    // A result beat always carries at least one tick.
    a_ticks_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> result.tick_count != '0)
        else $error("result beat with zero ticks");

    // An unsaturated duration is at least as large as the tick count.
    a_dur_ge_ticks: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.duration_q16 != {DUR_W{1'b1}})
        |-> result.duration_q16 >= DUR_W'(result.tick_count))
        else $error("duration shorter than tick count");

    // No result beat leaves the block while it is held in reset.
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |=> !done)
        else $error("result beat during reset");

endmodule

bind intercept_duration_solver_core ids_checker u_ids_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .done   (done),
    .result (result)
);
